// ===== sv/fss_pkg.sv =====
`default_nettype none

package fss_pkg;

    localparam int MAX_HOLDERS_DEF = 4;
    localparam int WAIT_DEPTH_DEF  = 16;
    localparam int ACTOR_BITS_DEF  = 8;
    localparam int SLOT_TYPES_DEF  = 4;

    localparam int NUM_CAP_REGS = 4;
    localparam logic [2:0]  CAP_MELEE_RST  = 3'd3;
    localparam logic [2:0]  CAP_RANGED_RST = 3'd2;
    localparam logic [2:0]  CAP_SHIELD_RST = 3'd1;
    localparam logic [2:0]  CAP_HEAL_RST   = 3'd1;
    localparam logic [15:0] TIMEOUT_RST    = 16'd3000;

    typedef enum logic [2:0] {
        CFG_CAP_MELEE    = 3'd0,
        CFG_CAP_RANGED   = 3'd1,
        CFG_CAP_SHIELD   = 3'd2,
        CFG_CAP_HEAL     = 3'd3,
        CFG_WAIT_TIMEOUT = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_RETIRE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        MODE_EXPIRE,
        MODE_CHECK,
        MODE_RETIRE
    } pool_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EXPIRE,
        ST_DECIDE,
        ST_CHECK,
        ST_GRANT,
        ST_RETIRE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  slot_type;
        logic [7:0]  actor_id;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic       granted;
        logic [2:0] holder_count;
        logic [4:0] waiter_count;
        logic       queue_full;
    } out_item_t;

    typedef struct packed {
        pool_mode_t mode;
        logic       start;
        logic       rotate;
        logic       refresh;
        logic       insert;
        logic       clear_me;
        logic       add_holder;
        logic       drop_holder;
    } pool_ctrl_t;

    typedef struct packed {
        logic is_holder;
        logic found;
        logic blocked;
        logic has_free;
    } pool_stat_t;

endpackage

`default_nettype wire

// ===== sv/fss_cell.sv =====
`default_nettype none

module fss_cell #(
    parameter int AW = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          shift_en,
    input  wire logic          in_valid,
    input  wire logic [AW-1:0] in_actor,
    input  wire logic [31:0]   in_first,
    input  wire logic [31:0]   in_last,
    input  wire logic          wr_en,
    input  wire logic          clr_en,
    input  wire logic [AW-1:0] wr_actor,
    input  wire logic [31:0]   wr_time,
    output logic               valid,
    output logic [AW-1:0]      actor,
    output logic [31:0]        first,
    output logic [31:0]        last
);

    logic          valid_reg;
    logic [AW-1:0] actor_reg;
    logic [31:0]   first_reg;
    logic [31:0]   last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= in_valid;
        end else if (wr_en) begin
            valid_reg <= 1'b1;
        end else if (clr_en) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            actor_reg <= in_actor;
            first_reg <= in_first;
            last_reg  <= in_last;
        end else if (wr_en) begin
            actor_reg <= wr_actor;
            first_reg <= wr_time;
            last_reg  <= wr_time;
        end
    end

    assign valid = valid_reg;
    assign actor = actor_reg;
    assign first = first_reg;
    assign last  = last_reg;

endmodule

`default_nettype wire

// ===== sv/fss_pool.sv =====
`default_nettype none

module fss_pool import fss_pkg::*; #(
    parameter int AW  = 8,
    parameter int D   = 16,
    parameter int H   = 4,
    parameter int IW  = 4,
    parameter int WCW = 5,
    parameter int HCW = 3
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire pool_ctrl_t     ctrl,
    input  wire logic [AW-1:0]  actor,
    input  wire logic [31:0]    now,
    input  wire logic [15:0]    timeout,
    input  wire logic [IW-1:0]  step,
    output pool_stat_t          stat,
    output logic [HCW-1:0]      hold_cnt,
    output logic [WCW-1:0]      wait_cnt
);

    logic          c_valid [D];
    logic [AW-1:0] c_actor [D];
    logic [31:0]   c_first [D];
    logic [31:0]   c_last  [D];
    logic          n_valid [D];
    logic [AW-1:0] n_actor [D];
    logic [31:0]   n_first [D];
    logic [31:0]   n_last  [D];

    logic          found_reg;
    logic          blocked_reg;
    logic          has_free_reg;
    logic [31:0]   mine_reg;
    logic [IW-1:0] free_idx_reg;
    logic [IW-1:0] me_idx_reg;
    logic [WCW-1:0] wait_cnt_reg;

    logic          h_valid [H];
    logic [AW-1:0] h_actor [H];
    logic [HCW-1:0] hold_cnt_reg;

    logic [31:0] h_age;
    logic        h_expired;
    logic        h_match;
    logic        h_drop;
    logic [31:0] h_diff;
    logic        is_holder;
    logic        hold_free_found;
    logic [H-1:0] hold_add_sel;

    // head of the chain: the cell that is inspected this cycle
    always_comb begin
        h_age     = now - c_last[0];
        h_expired = c_valid[0] && (h_age > {16'd0, timeout});
        h_match   = c_valid[0] && (c_actor[0] == actor);
        h_drop    = ((ctrl.mode == MODE_EXPIRE) && h_expired) ||
                    ((ctrl.mode == MODE_RETIRE) && h_match);
        h_diff    = mine_reg - c_first[0];
    end

    always_comb begin
        for (int i = 0; i < D - 1; i++) begin
            n_valid[i] = c_valid[i+1];
            n_actor[i] = c_actor[i+1];
            n_first[i] = c_first[i+1];
            n_last[i]  = c_last[i+1];
        end
        n_valid[D-1] = c_valid[0] && !h_drop;
        n_actor[D-1] = c_actor[0];
        n_first[D-1] = c_first[0];
        n_last[D-1]  = (ctrl.mode == MODE_EXPIRE && h_match && !h_expired && ctrl.refresh) ?
                       now : c_last[0];
    end

    for (genvar i = 0; i < D; i++) begin : g_cell
        fss_cell #(.AW(AW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (ctrl.rotate),
            .in_valid (n_valid[i]),
            .in_actor (n_actor[i]),
            .in_first (n_first[i]),
            .in_last  (n_last[i]),
            .wr_en    (ctrl.insert && (free_idx_reg == IW'(i))),
            .clr_en   (ctrl.clear_me && (me_idx_reg == IW'(i))),
            .wr_actor (actor),
            .wr_time  (now),
            .valid    (c_valid[i]),
            .actor    (c_actor[i]),
            .first    (c_first[i]),
            .last     (c_last[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg    <= 1'b0;
            blocked_reg  <= 1'b0;
            has_free_reg <= 1'b0;
            wait_cnt_reg <= '0;
        end else begin
            if (ctrl.start) begin
                found_reg    <= 1'b0;
                blocked_reg  <= 1'b0;
                has_free_reg <= 1'b0;
            end else if (ctrl.rotate) begin
                if (h_drop) begin
                    wait_cnt_reg <= wait_cnt_reg - 1'b1;
                end
                if (ctrl.mode == MODE_EXPIRE) begin
                    if (h_match && !h_expired) begin
                        found_reg <= 1'b1;
                    end
                    if ((!c_valid[0] || h_expired) && !has_free_reg) begin
                        has_free_reg <= 1'b1;
                    end
                end else if (ctrl.mode == MODE_CHECK) begin
                    // another waiter asked strictly earlier
                    if (c_valid[0] && !h_match && h_diff != 32'd0 && !h_diff[31]) begin
                        blocked_reg <= 1'b1;
                    end
                end
            end else if (ctrl.insert) begin
                wait_cnt_reg <= wait_cnt_reg + 1'b1;
            end else if (ctrl.clear_me) begin
                wait_cnt_reg <= wait_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rotate && ctrl.mode == MODE_EXPIRE) begin
            if (h_match && !h_expired) begin
                mine_reg <= c_first[0];
            end
            if ((!c_valid[0] || h_expired) && !has_free_reg) begin
                free_idx_reg <= step;
            end
        end else if (ctrl.rotate && ctrl.mode == MODE_CHECK) begin
            if (h_match) begin
                me_idx_reg <= step;
            end
        end else if (ctrl.insert) begin
            mine_reg <= now;
        end
    end

    // holder set, order does not matter
    always_comb begin
        is_holder       = 1'b0;
        hold_free_found = 1'b0;
        hold_add_sel    = '0;
        for (int i = 0; i < H; i++) begin
            if (h_valid[i] && h_actor[i] == actor) begin
                is_holder = 1'b1;
            end
            if (!h_valid[i] && !hold_free_found) begin
                hold_free_found = 1'b1;
                hold_add_sel[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < H; i++) begin
                h_valid[i] <= 1'b0;
            end
            hold_cnt_reg <= '0;
        end else if (ctrl.add_holder) begin
            for (int i = 0; i < H; i++) begin
                if (hold_add_sel[i]) begin
                    h_valid[i] <= 1'b1;
                end
            end
            hold_cnt_reg <= hold_cnt_reg + 1'b1;
        end else if (ctrl.drop_holder && is_holder) begin
            for (int i = 0; i < H; i++) begin
                if (h_valid[i] && h_actor[i] == actor) begin
                    h_valid[i] <= 1'b0;
                end
            end
            hold_cnt_reg <= hold_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.add_holder) begin
            for (int i = 0; i < H; i++) begin
                if (hold_add_sel[i]) begin
                    h_actor[i] <= actor;
                end
            end
        end
    end

    assign stat.is_holder = is_holder;
    assign stat.found     = found_reg;
    assign stat.blocked   = blocked_reg;
    assign stat.has_free  = has_free_reg;
    assign hold_cnt       = hold_cnt_reg;
    assign wait_cnt       = wait_cnt_reg;

    a_wait_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wait_cnt_reg) <= D)
        else $error("waiter count above depth");

    a_hold_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(hold_cnt_reg) <= H)
        else $error("holder count above limit");

    a_insert_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.insert |-> has_free_reg && !found_reg)
        else $error("waiter insert without a free cell");

    a_add_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.add_holder |-> hold_free_found)
        else $error("holder add with full holder set");

endmodule

`default_nettype wire

// ===== sv/fair_slot_semaphore_with_wait_expiry.sv =====
// Fair counting semaphore over several slot pools with waiter expiry.
// Input channel s_valid/s_ready/s_data carries one request transaction
// (acquire, release, query, retire); the result channel m_valid/m_ready/m_data
// returns exactly one result transaction per request.
// Each pool keeps its waiters in a ring of WAIT_DEPTH cells; a pass rotates
// the ring once, one cell past the head logic per cycle.
// Sequence from accept to result:
//   acquire: expiry pass, then decide; when a grant is attempted, the
//            fairness pass and the grant step follow
//   retire:  one pass over every pool at once
//   release, query, null actor, pool out of range: straight to the result
// One request is in work at a time; the next one is accepted only after
// its result is loaded into the output register.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls, a second result holds the block
// until the register frees.
// Reset (aresetn low, synchronous) empties all holder sets and waiter lists
// and loads the default capacities and a 3000 ms timeout. Configuration
// writes through cfg_we/cfg_index/cfg_wdata must come only while idle.
`default_nettype none

module fair_slot_semaphore_with_wait_expiry import fss_pkg::*; #(
    parameter int MAX_HOLDERS = MAX_HOLDERS_DEF,
    parameter int WAIT_DEPTH  = WAIT_DEPTH_DEF,
    parameter int ACTOR_BITS  = ACTOR_BITS_DEF,
    parameter int SLOT_TYPES  = SLOT_TYPES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int AW  = ACTOR_BITS;
    localparam int D   = WAIT_DEPTH;
    localparam int H   = MAX_HOLDERS;
    localparam int IW  = $clog2(WAIT_DEPTH);
    localparam int WCW = $clog2(WAIT_DEPTH + 1);
    localparam int HCW = $clog2(MAX_HOLDERS + 1);
    localparam int PW  = (SLOT_TYPES > 1) ? $clog2(SLOT_TYPES) : 1;

    state_t     state_reg, state_next;
    in_item_t   in_reg;
    logic [IW-1:0] step_reg, step_next;
    logic       granted_reg, granted_next;
    logic       full_reg, full_next;
    logic       m_valid_reg;
    out_item_t  m_data_reg;
    logic       load_out;

    logic [2:0]  cap_reg [NUM_CAP_REGS];
    logic [15:0] timeout_reg;
    logic [HCW-1:0] cap_sat [SLOT_TYPES];

    pool_ctrl_t     ctrl [SLOT_TYPES];
    pool_stat_t     stat [SLOT_TYPES];
    logic [HCW-1:0] hold_cnt [SLOT_TYPES];
    logic [WCW-1:0] wait_cnt [SLOT_TYPES];

    logic [AW-1:0] actor;
    logic          in_range;
    logic [PW-1:0] p_idx;
    logic          step_last;
    pool_stat_t    sel_stat;
    logic [HCW-1:0] sel_hold;
    logic [WCW-1:0] sel_wait;
    logic [HCW-1:0] sel_cap;
    out_item_t     result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg[0]  <= CAP_MELEE_RST;
            cap_reg[1]  <= CAP_RANGED_RST;
            cap_reg[2]  <= CAP_SHIELD_RST;
            cap_reg[3]  <= CAP_HEAL_RST;
            timeout_reg <= TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CAP_MELEE:    cap_reg[0]  <= cfg_wdata[2:0];
                CFG_CAP_RANGED:   cap_reg[1]  <= cfg_wdata[2:0];
                CFG_CAP_SHIELD:   cap_reg[2]  <= cfg_wdata[2:0];
                CFG_CAP_HEAL:     cap_reg[3]  <= cfg_wdata[2:0];
                CFG_WAIT_TIMEOUT: timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // capacity per pool, pools without a register have none
    always_comb begin
        for (int q = 0; q < SLOT_TYPES; q++) begin
            if (q < NUM_CAP_REGS) begin
                if (32'(cap_reg[2'(q)]) > H) begin
                    cap_sat[q] = HCW'(H);
                end else begin
                    cap_sat[q] = HCW'(cap_reg[2'(q)]);
                end
            end else begin
                cap_sat[q] = '0;
            end
        end
    end

    assign actor     = AW'(in_reg.actor_id);
    assign in_range  = 32'(in_reg.slot_type) < SLOT_TYPES;
    assign p_idx     = PW'(in_reg.slot_type);
    assign step_last = (step_reg == IW'(D - 1));

    always_comb begin
        sel_stat = '0;
        sel_hold = '0;
        sel_wait = '0;
        sel_cap  = '0;
        for (int q = 0; q < SLOT_TYPES; q++) begin
            if (p_idx == PW'(q)) begin
                sel_stat = stat[q];
                sel_hold = hold_cnt[q];
                sel_wait = wait_cnt[q];
                sel_cap  = cap_sat[q];
            end
        end
    end

    for (genvar q = 0; q < SLOT_TYPES; q++) begin : g_pool
        fss_pool #(
            .AW  (AW),
            .D   (D),
            .H   (H),
            .IW  (IW),
            .WCW (WCW),
            .HCW (HCW)
        ) u_pool (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl[q]),
            .actor    (actor),
            .now      (in_reg.now_ms),
            .timeout  (timeout_reg),
            .step     (step_reg),
            .stat     (stat[q]),
            .hold_cnt (hold_cnt[q]),
            .wait_cnt (wait_cnt[q])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            granted_reg <= 1'b0;
            full_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            granted_reg <= granted_next;
            full_reg    <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        granted_next = granted_reg;
        full_next    = full_reg;
        load_out     = 1'b0;
        for (int q = 0; q < SLOT_TYPES; q++) begin
            ctrl[q] = '0;
            ctrl[q].mode = MODE_EXPIRE;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                granted_next = 1'b0;
                full_next    = 1'b0;
                step_next    = '0;
                state_next   = ST_RESULT;
                if (in_range && actor != '0) begin
                    case (in_reg.req_type)
                        REQ_ACQUIRE: begin
                            ctrl[p_idx].start = 1'b1;
                            state_next = ST_EXPIRE;
                        end
                        REQ_RELEASE: begin
                            ctrl[p_idx].drop_holder = 1'b1;
                        end
                        REQ_QUERY: begin
                            granted_next = sel_stat.is_holder;
                        end
                        REQ_RETIRE: begin
                            for (int q = 0; q < SLOT_TYPES; q++) begin
                                ctrl[q].drop_holder = 1'b1;
                            end
                            state_next = ST_RETIRE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXPIRE: begin
                ctrl[p_idx].rotate  = 1'b1;
                ctrl[p_idx].mode    = MODE_EXPIRE;
                ctrl[p_idx].refresh = !sel_stat.is_holder;
                step_next = step_reg + 1'b1;
                if (step_last) begin
                    step_next  = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_RESULT;
                if (sel_stat.is_holder) begin
                    granted_next = 1'b1;
                end else if (!sel_stat.found && sel_wait == WCW'(D)) begin
                    full_next = 1'b1;
                end else begin
                    if (!sel_stat.found) begin
                        ctrl[p_idx].insert = 1'b1;
                    end
                    if (sel_hold < sel_cap) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                ctrl[p_idx].rotate = 1'b1;
                ctrl[p_idx].mode   = MODE_CHECK;
                step_next = step_reg + 1'b1;
                if (step_last) begin
                    step_next  = '0;
                    state_next = ST_GRANT;
                end
            end
            ST_GRANT: begin
                state_next = ST_RESULT;
                if (!sel_stat.blocked) begin
                    ctrl[p_idx].clear_me   = 1'b1;
                    ctrl[p_idx].add_holder = 1'b1;
                    granted_next = 1'b1;
                end
            end
            ST_RETIRE: begin
                for (int q = 0; q < SLOT_TYPES; q++) begin
                    ctrl[q].rotate = 1'b1;
                    ctrl[q].mode   = MODE_RETIRE;
                end
                step_next = step_reg + 1'b1;
                if (step_last) begin
                    step_next  = '0;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        result = '0;
        if (in_range) begin
            result.granted      = granted_reg;
            result.holder_count = 3'(sel_hold);
            result.waiter_count = 5'(sel_wait);
            result.queue_full   = full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= result;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== tb/semaphore_checker.sv =====
`timescale 1ns / 100ps

module semaphore_checker import fss_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_item_t    s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_item_t   m_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);

    localparam int NPOOL = 4;
    localparam int NHOLD = 4;
    localparam int NWAIT = 16;

    logic [2:0]  pool_cap [NPOOL];
    logic [15:0] timeout_ms;
    logic [7:0]  holders [NPOOL][NHOLD];
    int          hold_n [NPOOL];
    logic [7:0]  wait_id [NPOOL][NWAIT];
    logic [31:0] wait_first [NPOOL][NWAIT];
    logic [31:0] wait_last [NPOOL][NWAIT];
    int          wait_n [NPOOL];
    out_item_t   expected_results [$];

    function automatic int pool_limit(int p);
        return (pool_cap[p] > NHOLD) ? NHOLD : int'(pool_cap[p]);
    endfunction

    function automatic void remove_waiter(int p, int i);
        for (int k = i; k + 1 < wait_n[p]; k++) begin
            wait_id[p][k]    = wait_id[p][k + 1];
            wait_first[p][k] = wait_first[p][k + 1];
            wait_last[p][k]  = wait_last[p][k + 1];
        end
        wait_n[p]--;
    endfunction

    function automatic void remove_holder(int p, logic [7:0] a);
        for (int i = 0; i < hold_n[p]; i++) begin
            if (holders[p][i] == a) begin
                for (int k = i; k + 1 < hold_n[p]; k++) holders[p][k] = holders[p][k + 1];
                hold_n[p]--;
                return;
            end
        end
    endfunction

    function automatic int waiter_slot(int p, logic [7:0] a);
        for (int i = 0; i < wait_n[p]; i++) if (wait_id[p][i] == a) return i;
        return -1;
    endfunction

    function automatic bit holds_slot(int p, logic [7:0] a);
        for (int i = 0; i < hold_n[p]; i++) if (holders[p][i] == a) return 1;
        return 0;
    endfunction

    function automatic void semaphore_reset();
        pool_cap[0] = CAP_MELEE_RST;
        pool_cap[1] = CAP_RANGED_RST;
        pool_cap[2] = CAP_SHIELD_RST;
        pool_cap[3] = CAP_HEAL_RST;
        timeout_ms = TIMEOUT_RST;
        for (int p = 0; p < NPOOL; p++) begin
            hold_n[p] = 0;
            wait_n[p] = 0;
        end
    endfunction

    function automatic out_item_t serve_request(in_item_t rq);
        out_item_t   r;
        int          p;
        int          me;
        int          i;
        logic [7:0]  a;
        logic [31:0] now;
        logic [31:0] d;
        bit          blocked;
        r = '0;
        p = int'(rq.slot_type);
        a = rq.actor_id;
        now = rq.now_ms;
        if (a != 0) begin
            case (req_t'(rq.req_type))
                REQ_ACQUIRE: begin
                    i = 0;
                    while (i < wait_n[p]) begin
                        d = now - wait_last[p][i];
                        if (d > {16'd0, timeout_ms}) remove_waiter(p, i);
                        else i++;
                    end
                    if (holds_slot(p, a)) begin
                        r.granted = 1;
                    end else begin
                        me = waiter_slot(p, a);
                        if (me < 0 && wait_n[p] >= NWAIT) begin
                            r.queue_full = 1;
                        end else begin
                            if (me < 0) begin
                                me = wait_n[p];
                                wait_id[p][me] = a;
                                wait_first[p][me] = now;
                                wait_n[p]++;
                            end
                            wait_last[p][me] = now;
                            if (hold_n[p] < pool_limit(p)) begin
                                blocked = 0;
                                for (i = 0; i < wait_n[p]; i++) begin
                                    d = wait_first[p][me] - wait_first[p][i];
                                    if (i != me && d != 0 && d < 32'h8000_0000) blocked = 1;
                                end
                                if (!blocked) begin
                                    remove_waiter(p, me);
                                    holders[p][hold_n[p]] = a;
                                    hold_n[p]++;
                                    r.granted = 1;
                                end
                            end
                        end
                    end
                end
                REQ_RELEASE: remove_holder(p, a);
                REQ_QUERY:   r.granted = holds_slot(p, a);
                default: begin
                    for (int q = 0; q < NPOOL; q++) begin
                        remove_holder(q, a);
                        me = waiter_slot(q, a);
                        if (me >= 0) remove_waiter(q, me);
                    end
                end
            endcase
        end
        r.holder_count = 3'(hold_n[p]);
        r.waiter_count = 5'(wait_n[p]);
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            semaphore_reset();
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index < CFG_WAIT_TIMEOUT) pool_cap[cfg_index[1:0]] = cfg_wdata[2:0];
                else if (cfg_index == CFG_WAIT_TIMEOUT) timeout_ms = cfg_wdata;
            end
            if (s_valid && s_ready) expected_results.push_back(serve_request(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== m_data) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import fss_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          quiet_mode;
    bit          hold_off;
    logic [31:0] clock_ms;

    fair_slot_semaphore_with_wait_expiry u_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_we, .cfg_index, .cfg_wdata
    );

    semaphore_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stall bursts, or one long hold-off to back the block up
    initial begin
        int n;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                hold_off = 0;
                m_ready <= 1;
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                m_ready <= 0;
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_ready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // valid stays high after the accept edge; the next call or the caller drops it
    task automatic send_request(req_t rq, logic [1:0] pool, logic [7:0] actor,
                                logic [31:0] now);
        if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_data <= '{req_type: rq, slot_type: pool, actor_id: actor, now_ms: now};
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic random_phase(int count, int actors);
        for (int i = 0; i < count; i++) begin
            clock_ms = clock_ms + $urandom_range(0, 1500);
            if ($urandom_range(0, 30) == 0) clock_ms = $urandom;
            send_request(($urandom_range(0, 9) < 6) ? REQ_ACQUIRE : req_t'($urandom_range(1, 3)),
                         2'($urandom_range(0, 3)),
                         ($urandom_range(0, 20) == 0) ? 8'($urandom) :
                         8'($urandom_range(0, actors)), clock_ms);
        end
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_we = 0;
        cfg_index = CFG_CAP_MELEE;
        cfg_wdata = 0;
        quiet_mode = 0;
        hold_off = 0;
        clock_ms = 32'd1000;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: grants, fairness, full waiter list, null actor, wrap-around
        send_request(REQ_ACQUIRE, 2'd0, 8'd1, 32'd100);
        send_request(REQ_ACQUIRE, 2'd0, 8'd1, 32'd110);
        send_request(REQ_QUERY,   2'd0, 8'd1, 32'd120);
        send_request(REQ_ACQUIRE, 2'd3, 8'd2, 32'd130);
        send_request(REQ_ACQUIRE, 2'd3, 8'd3, 32'd140);
        send_request(REQ_ACQUIRE, 2'd3, 8'd4, 32'd150);
        send_request(REQ_RELEASE, 2'd3, 8'd2, 32'd160);
        send_request(REQ_ACQUIRE, 2'd3, 8'd4, 32'd170);
        send_request(REQ_ACQUIRE, 2'd3, 8'd3, 32'd180);
        send_request(REQ_ACQUIRE, 2'd0, 8'd0, 32'd190);
        send_request(REQ_RETIRE,  2'd2, 8'd255, 32'd200);
        send_request(REQ_RETIRE,  2'd1, 8'd3, 32'd210);
        send_request(REQ_RELEASE, 2'd1, 8'd77, 32'd215);
        for (int i = 0; i < 18; i++) send_request(REQ_ACQUIRE, 2'd2, 8'(10 + i), 32'd300);
        send_request(REQ_ACQUIRE, 2'd2, 8'd50, 32'hFFFF_FFF0);
        send_request(REQ_QUERY,   2'd2, 8'd10, 32'h0000_0010);

        write_reg(CFG_CAP_MELEE, 16'd0);
        write_reg(CFG_CAP_RANGED, 16'd4);
        write_reg(CFG_CAP_SHIELD, 16'd7);
        write_reg(CFG_CAP_HEAL, 16'd2);
        write_reg(CFG_WAIT_TIMEOUT, 16'd0);
        random_phase(150, 12);

        write_reg(CFG_WAIT_TIMEOUT, 16'hFFFF);
        write_reg(CFG_CAP_MELEE, 16'd4);
        // long receiver hold-off while requests keep coming
        hold_off = 1;
        random_phase(200, 30);

        write_reg(CFG_WAIT_TIMEOUT, 16'd1200);
        write_reg(CFG_CAP_RANGED, 16'd1);
        write_reg(CFG_CAP_HEAL, 16'd0);
        random_phase(250, 20);

        write_reg(CFG_WAIT_TIMEOUT, 16'd3000);
        write_reg(CFG_CAP_SHIELD, 16'd3);
        write_reg(CFG_CAP_HEAL, 16'd4);
        random_phase(200, 40);
        quiet_mode = 1;
        random_phase(70, 10);
        s_valid <= 0;

        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
